// ===== src/msst_pkg.sv =====
`default_nettype none
package msst_pkg;
	localparam int DIV_W = 96;
	localparam int DVR_W = 33;
	localparam int MA_W  = 64;
	localparam int MB_W  = 32;
	localparam int MP_W  = MA_W + MB_W;
	localparam int SQ_W  = 64;
	localparam int RT_W  = 32;

	typedef logic [DIV_W-1:0] div_word_t;
	typedef logic [DVR_W-1:0] dvr_word_t;
	typedef logic [MA_W-1:0]  mul_a_t;
	typedef logic [MB_W-1:0]  mul_b_t;
	typedef logic [MP_W-1:0]  mul_p_t;
	typedef logic [SQ_W-1:0]  sq_word_t;
	typedef logic [RT_W-1:0]  root_t;
endpackage
`default_nettype wire

// ===== src/multilevel_sample_statistics.sv =====
`default_nettype none
// Per-level running statistics (count, mean, squared deviations, mean cost)
// with next-level choice. start is taken when busy is low; busy stays high
// until the result word is shown on done for one cycle, and the receiver
// cannot stall it. All arithmetic goes through one serial divider,
// one shift-add multiplier and one bit-pair square root under a
// sequencer. A record updates one level with two multiplies and three
// divides, then sums the active level means into the estimate. A choose
// runs two divides and a square root per level with two or more samples
// and non-zero cost, then scans levels from the top. active_levels may
// only be written while idle.
module multilevel_sample_statistics #(
	parameter int MAX_LEVELS = 8,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [2:0]         level,
	input  logic signed [31:0] sample_value,
	input  logic [31:0]        sample_cost,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	output logic               done,
	output logic               chosen_valid,
	output logic [2:0]         chosen_level,
	output logic               fixed_level_kind,
	output logic signed [35:0] estimate
);
	import msst_pkg::*;

	localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LVW = LW + 1;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_R0    = 5'd1;
	localparam logic [4:0] S_RM1   = 5'd2;
	localparam logic [4:0] S_RM1W  = 5'd3;
	localparam logic [4:0] S_RM2   = 5'd4;
	localparam logic [4:0] S_RM2W  = 5'd5;
	localparam logic [4:0] S_RD1   = 5'd6;
	localparam logic [4:0] S_RD1W  = 5'd7;
	localparam logic [4:0] S_RD2   = 5'd8;
	localparam logic [4:0] S_RD2W  = 5'd9;
	localparam logic [4:0] S_RD3   = 5'd10;
	localparam logic [4:0] S_RD3W  = 5'd11;
	localparam logic [4:0] S_CINIT = 5'd12;
	localparam logic [4:0] S_CLVL  = 5'd13;
	localparam logic [4:0] S_CD1   = 5'd14;
	localparam logic [4:0] S_CD1W  = 5'd15;
	localparam logic [4:0] S_CD2   = 5'd16;
	localparam logic [4:0] S_CD2W  = 5'd17;
	localparam logic [4:0] S_CSQ   = 5'd18;
	localparam logic [4:0] S_CSQW  = 5'd19;
	localparam logic [4:0] S_SCAN0 = 5'd20;
	localparam logic [4:0] S_SM1   = 5'd21;
	localparam logic [4:0] S_SM1W  = 5'd22;
	localparam logic [4:0] S_SM2   = 5'd23;
	localparam logic [4:0] S_SM2W  = 5'd24;
	localparam logic [4:0] S_EST0  = 5'd25;
	localparam logic [4:0] S_EST   = 5'd26;
	localparam logic [4:0] S_OUT   = 5'd27;

	logic [4:0]  state_q;
	logic [3:0]  active_q;

	logic [31:0] cnt_q   [MAX_LEVELS];
	logic [31:0] mean_q  [MAX_LEVELS];
	logic [63:0] sqd_q   [MAX_LEVELS];
	logic [31:0] cost_q  [MAX_LEVELS];
	logic [31:0] prop_q  [MAX_LEVELS];

	logic            typ_q;
	logic [2:0]      rlev_q;
	logic [31:0]     x_q;
	logic [31:0]     c_q;
	logic [LVW-1:0]  lvl_q;
	logic [31:0]     ad_q;
	logic            dneg_q;
	logic [31:0]     adc_q;
	logic            dcneg_q;
	logic [31:0]     n_q;
	logic [32:0]     np1_q;
	logic [63:0]     dd_q;
	logic [35:0]     total_q;
	logic [35:0]     tprop_q;
	logic [63:0]     r_q;
	logic [MP_W-1:0] lhs_q;
	logic [35:0]     est_q;
	logic            vld_q;
	logic [LVW-1:0]  chs_q;
	logic            kind_q;

	logic            done_q;
	logic            ov_q;
	logic [2:0]      ol_q;
	logic            ok_q;
	logic [35:0]     oe_q;

	logic [4:0]      eff5;
	logic [LVW-1:0]  eff;
	logic [LW-1:0]   idx;
	logic            rec_ok;

	logic [32:0]     d;
	logic [32:0]     dc;
	logic [31:0]     dq;
	logic [64:0]     sqsum;
	logic [63:0]     term;

	logic            mul_go, mul_done;
	mul_a_t          mul_a;
	mul_b_t          mul_b;
	mul_p_t          mul_prod;
	logic            div_go, div_done;
	div_word_t       div_n;
	dvr_word_t       div_d;
	div_word_t       div_quot;
	logic            sq_go, sq_done;
	root_t           sq_root;

	always_comb begin
		if (active_q == 4'd0) begin
			eff5 = 5'd1;
		end else if ({1'b0, active_q} > 5'(MAX_LEVELS)) begin
			eff5 = 5'(MAX_LEVELS);
		end else begin
			eff5 = {1'b0, active_q};
		end
	end
	assign eff    = LVW'(eff5);
	assign idx    = lvl_q[LW-1:0];
	assign rec_ok = {2'b00, rlev_q} < eff5;

	assign d     = {x_q[31], x_q} - {mean_q[idx][31], mean_q[idx]};
	assign dc    = {1'b0, c_q} - {1'b0, cost_q[idx]};
	assign dq    = div_quot[31:0];
	assign term  = div_quot[63:0] >> FRAC_BITS;
	assign sqsum = {1'b0, sqd_q[idx]} + {1'b0, term};

	assign mul_go = (state_q == S_RM1) || (state_q == S_RM2) ||
	                (state_q == S_SM1) || (state_q == S_SM2);
	assign div_go = (state_q == S_RD1) || (state_q == S_RD2) ||
	                (state_q == S_RD3) || (state_q == S_CD1) || (state_q == S_CD2);
	assign sq_go  = (state_q == S_CSQ);

	always_comb begin
		case (state_q)
			S_RM1: begin
				mul_a = {32'b0, ad_q};
				mul_b = ad_q;
			end
			S_RM2: begin
				mul_a = dd_q;
				mul_b = n_q;
			end
			S_SM1: begin
				mul_a = {28'b0, tprop_q};
				mul_b = cnt_q[idx];
			end
			default: begin
				mul_a = {28'b0, total_q};
				mul_b = prop_q[idx];
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_RD1: begin
				div_n = mul_prod;
				div_d = np1_q;
			end
			S_RD2: begin
				div_n = {64'b0, ad_q};
				div_d = np1_q;
			end
			S_RD3: begin
				div_n = {64'b0, adc_q};
				div_d = np1_q;
			end
			S_CD1: begin
				div_n = {32'b0, sqd_q[idx]};
				div_d = {1'b0, cnt_q[idx] - 32'd1};
			end
			default: begin
				div_n = {32'b0, div_quot[63:0]} << FRAC_BITS;
				div_d = {1'b0, cost_q[idx]};
			end
		endcase
	end

	msst_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	msst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (div_quot)
	);

	msst_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_go),
		.radicand (r_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= 4'd8;
			done_q   <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				cnt_q[i]  <= '0;
				mean_q[i] <= '0;
				sqd_q[i]  <= '0;
				cost_q[i] <= '0;
			end
		end else begin
			done_q <= (state_q == S_OUT);
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= req_type ? S_CINIT : S_R0;
					end
				end
				S_R0: begin
					state_q <= rec_ok ? S_RM1 : S_EST0;
				end
				S_RM1: state_q <= S_RM1W;
				S_RM1W: begin
					if (mul_done) begin
						state_q <= S_RM2;
					end
				end
				S_RM2: state_q <= S_RM2W;
				S_RM2W: begin
					if (mul_done) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD1W;
				S_RD1W: begin
					if (div_done) begin
						sqd_q[idx] <= sqsum[64] ? '1 : sqsum[63:0];
						state_q    <= S_RD2;
					end
				end
				S_RD2: state_q <= S_RD2W;
				S_RD2W: begin
					if (div_done) begin
						mean_q[idx] <= dneg_q ? mean_q[idx] - dq : mean_q[idx] + dq;
						state_q     <= S_RD3;
					end
				end
				S_RD3: state_q <= S_RD3W;
				S_RD3W: begin
					if (div_done) begin
						cost_q[idx] <= dcneg_q ? cost_q[idx] - dq : cost_q[idx] + dq;
						if (cnt_q[idx] != '1) begin
							cnt_q[idx] <= cnt_q[idx] + 32'd1;
						end
						state_q <= S_EST0;
					end
				end
				S_CINIT: state_q <= S_CLVL;
				S_CLVL: begin
					if (lvl_q == eff) begin
						state_q <= S_SCAN0;
					end else if (cnt_q[idx] >= 32'd2 && cost_q[idx] != '0) begin
						state_q <= S_CD1;
					end
				end
				S_CD1: state_q <= S_CD1W;
				S_CD1W: begin
					if (div_done) begin
						state_q <= S_CD2;
					end
				end
				S_CD2: state_q <= S_CD2W;
				S_CD2W: begin
					if (div_done) begin
						state_q <= S_CSQ;
					end
				end
				S_CSQ: state_q <= S_CSQW;
				S_CSQW: begin
					if (sq_done) begin
						state_q <= S_CLVL;
					end
				end
				S_SCAN0: begin
					state_q <= (total_q == '0 || tprop_q == '0) ? S_EST0 : S_SM1;
				end
				S_SM1: state_q <= S_SM1W;
				S_SM1W: begin
					if (mul_done) begin
						state_q <= S_SM2;
					end
				end
				S_SM2: state_q <= S_SM2W;
				S_SM2W: begin
					if (mul_done) begin
						if (lhs_q < mul_prod || lvl_q == '0) begin
							state_q <= S_EST0;
						end else begin
							state_q <= S_SM1;
						end
					end
				end
				S_EST0: state_q <= S_EST;
				S_EST: begin
					if (lvl_q == eff) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				typ_q  <= req_type;
				rlev_q <= level;
				x_q    <= sample_value;
				c_q    <= sample_cost;
				lvl_q  <= LVW'(level);
				vld_q  <= 1'b0;
				chs_q  <= '0;
				kind_q <= 1'b0;
			end
			S_R0: begin
				dneg_q  <= d[32];
				ad_q    <= d[32] ? 32'(-d) : d[31:0];
				dcneg_q <= dc[32];
				adc_q   <= dc[32] ? 32'(-dc) : dc[31:0];
				n_q     <= cnt_q[idx];
				np1_q   <= {1'b0, cnt_q[idx]} + 33'd1;
			end
			S_RM1W: begin
				if (mul_done) begin
					dd_q <= mul_prod[63:0];
				end
			end
			S_CINIT: begin
				lvl_q   <= '0;
				total_q <= '0;
				tprop_q <= '0;
			end
			S_CLVL: begin
				if (lvl_q != eff && (cnt_q[idx] < 32'd2 || cost_q[idx] == '0)) begin
					prop_q[idx] <= '0;
					total_q     <= total_q + {4'b0, cnt_q[idx]};
					lvl_q       <= lvl_q + 1'b1;
				end
			end
			S_CD2W: begin
				if (div_done) begin
					r_q <= (div_quot[DIV_W-1:64] != '0) ? '1 : div_quot[63:0];
				end
			end
			S_CSQW: begin
				if (sq_done) begin
					prop_q[idx] <= sq_root;
					tprop_q     <= tprop_q + {4'b0, sq_root};
					total_q     <= total_q + {4'b0, cnt_q[idx]};
					lvl_q       <= lvl_q + 1'b1;
				end
			end
			S_SCAN0: begin
				lvl_q <= eff - 1'b1;
			end
			S_SM1W: begin
				if (mul_done) begin
					lhs_q <= mul_prod;
				end
			end
			S_SM2W: begin
				if (mul_done) begin
					if (lhs_q < mul_prod) begin
						vld_q  <= 1'b1;
						chs_q  <= lvl_q;
						kind_q <= (lvl_q == eff - 1'b1);
					end else if (lvl_q != '0) begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
			end
			S_EST0: begin
				lvl_q <= '0;
				est_q <= '0;
			end
			S_EST: begin
				if (lvl_q != eff) begin
					est_q <= est_q + {{4{mean_q[idx][31]}}, mean_q[idx]};
					lvl_q <= lvl_q + 1'b1;
				end
			end
			S_OUT: begin
				ov_q <= vld_q & typ_q;
				ol_q <= 3'(chs_q);
				ok_q <= kind_q & typ_q;
				oe_q <= est_q;
			end
			default: begin
			end
		endcase
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign chosen_valid     = ov_q;
	assign chosen_level     = ol_q;
	assign fixed_level_kind = ok_q;
	assign estimate         = oe_q;
endmodule
`default_nettype wire

// ===== src/msst_div.sv =====
`default_nettype none
module msst_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  msst_pkg::div_word_t dividend,
	input  msst_pkg::dvr_word_t divisor,
	output logic                done,
	output msst_pkg::div_word_t quot
);
	import msst_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DVR_W-1:0] rem_q;
	logic [DVR_W-1:0] dvr_q;
	logic [DIV_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVR_W:0]   trial;
	logic [DVR_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvr_q};
	assign diff  = trial - {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CW'(DIV_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvr_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

// ===== src/msst_mul.sv =====
`default_nettype none
module msst_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  msst_pkg::mul_a_t a,
	input  msst_pkg::mul_b_t b,
	output logic             done,
	output msst_pkg::mul_p_t prod
);
	import msst_pkg::*;

	localparam int CW = $clog2(MB_W + 1);

	logic [MA_W-1:0] a_q;
	logic [MP_W-1:0] p_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;
	logic [MA_W:0]   sum;

	assign sum = {1'b0, p_q[MP_W-1:MB_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CW'(MB_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MB_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MA_W{1'b0}}, b};
		end else if (run_q) begin
			p_q <= {sum, p_q[MB_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;
endmodule
`default_nettype wire

// ===== src/msst_sqrt.sv =====
`default_nettype none
module msst_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  msst_pkg::sq_word_t radicand,
	output logic               done,
	output msst_pkg::root_t    root
);
	import msst_pkg::*;

	localparam int CW = $clog2(RT_W + 1);

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;
	logic [SQ_W-1:0] t;

	assign t = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CW'(RT_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(RT_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(SQ_W-2){1'b0}}};
		end else if (run_q) begin
			if (v_q >= t) begin
				v_q   <= v_q - t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[RT_W-1:0];
endmodule
`default_nettype wire
